// ----- rtl/sliding_window_stats_core_macros.svh -----
// assertion macros shared by the sliding window statistics rtl
`ifndef SLIDING_WINDOW_STATS_CORE_MACROS_SVH
`define SLIDING_WINDOW_STATS_CORE_MACROS_SVH

// condition holds at every clock edge out of reset
`define SWS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("sws check failed: invariant");

// condition implies a consequence in the same cycle
`define SWS_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("sws check failed: implication");

// condition implies a consequence in the next cycle
`define SWS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("sws check failed: next cycle");

`endif

// ----- rtl/sws_pkg.sv -----
// types and constants of the sliding window statistics block
`timescale 1ns / 1ps
`default_nettype none
package sws_pkg;

   // field widths
   localparam int SAMPLE_W   = 24;
   localparam int SUM_W      = 34;
   localparam int SUMSQ_W    = 57;
   localparam int PROD_W     = 48;
   localparam int COUNT_W    = 11;
   localparam int LEN_W      = 11;

   // register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0]       REG_WINDOW_LEN = 1'b0;
   localparam logic [LEN_W-1:0] LEN_RESET      = 11'd1024;

   // configuration seen by the datapath
   typedef struct packed {
      logic             wr_len;
      logic [LEN_W-1:0] window_len;
   } sws_cfg_type;

   // request sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_OLD,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } sws_state_type;

endpackage
`default_nettype wire

// ----- rtl/sws_ram.sv -----
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module sws_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- rtl/sws_csr.sv -----
// register file of the sliding window statistics block
`timescale 1ns / 1ps
`default_nettype none
module sws_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [sws_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [sws_pkg::CSR_DATA_W-1:0]     pwdata,
   output      logic [sws_pkg::CSR_DATA_W-1:0]     prdata,
   output      logic                               pready,
   output      sws_pkg::sws_cfg_type               cfg
);
   import sws_pkg::*;

   logic [LEN_W-1:0] window_len_ff;
   logic [LEN_W-1:0] window_len_in;
   logic             reg_sel;
   logic             wr_len;

   // address decode, one register per word
   assign reg_sel = (paddr[CSR_ADDR_W-1 -: 1] == REG_WINDOW_LEN);
   assign wr_len  = psel && penable && pwrite && reg_sel;

   always_comb begin
      window_len_in = window_len_ff;
      if (wr_len) begin
         window_len_in = pwdata[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= LEN_RESET;
      end else begin
         window_len_ff <= window_len_in;
      end
   end

   // read back and handshake
   assign prdata = reg_sel ? CSR_DATA_W'(window_len_ff) : '0;
   assign pready = 1'b1;

   assign cfg.wr_len     = wr_len;
   assign cfg.window_len = window_len_ff;

endmodule
`default_nettype wire

// ----- rtl/sliding_window_stats_core.sv -----
// Sliding window statistics core: each request pushes one signed 24-bit sample into a
// ring window of window_len samples (1 to CAPACITY) held in a single ram, and returns the
// sample count, exact sum, exact sum of squares, minimum and maximum of the window. A push
// runs from acceptance to the next acceptance through the ram read of the slot being
// overwritten, the write of the new sample with the sum and extreme update, and two passes
// through the one shared 24x24 squarer. When the evicted sample lay at or beyond the current
// minimum or maximum, the window is rebuilt by reading every held entry through the same
// ram port, one per cycle; such a rebuild reads L entries, where L is window_len with
// zero taken as one and values above CAPACITY taken as CAPACITY. A finished result waits in
// an output register while the next request is taken; a push that finishes while that
// register is still stalled holds in its last cycle until the register drains. Writing
// window_len empties the window and must be done with no request in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_stats_core_macros.svh"
module sliding_window_stats_core #(
   parameter int CAPACITY = 1024
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire logic signed [sws_pkg::SAMPLE_W-1:0]    req_sample,
   // result channel
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic [sws_pkg::COUNT_W-1:0]            rsp_count,
   output      logic signed [sws_pkg::SUM_W-1:0]       rsp_sum,
   output      logic [sws_pkg::SUMSQ_W-1:0]            rsp_sum_sq,
   output      logic signed [sws_pkg::SAMPLE_W-1:0]    rsp_minimum,
   output      logic signed [sws_pkg::SAMPLE_W-1:0]    rsp_maximum,
   // register port
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [sws_pkg::CSR_ADDR_W-1:0]         paddr,
   input  wire logic [sws_pkg::CSR_DATA_W-1:0]         pwdata,
   output      logic [sws_pkg::CSR_DATA_W-1:0]         prdata,
   output      logic                                   pready
);
   import sws_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int FILL_W = ADDR_W + 1;

   sws_cfg_type cfg;

   // sequencer
   sws_state_type state_ff, state_in;

   // request in flight
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [ADDR_W-1:0]          pos_ff, pos_in;
   logic signed [SAMPLE_W-1:0] old_ff, old_in;
   logic                       evict_ff, evict_in;

   // window statistics
   logic [ADDR_W-1:0]          widx_ff, widx_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUMSQ_W-1:0]         sumsq_ff, sumsq_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in;
   logic signed [SAMPLE_W-1:0] max_ff, max_in;

   // squarer output stage
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic                       prod_vld_ff, prod_vld_in;
   logic                       prod_neg_ff, prod_neg_in;

   // rescan
   logic [ADDR_W-1:0]          scan_addr_ff, scan_addr_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic                       scan_first_ff, scan_first_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]         rsp_count_ff;
   logic signed [SUM_W-1:0]    rsp_sum_ff;
   logic [SUMSQ_W-1:0]         rsp_sum_sq_ff;
   logic signed [SAMPLE_W-1:0] rsp_minimum_ff;
   logic signed [SAMPLE_W-1:0] rsp_maximum_ff;

   // ram port
   logic                       mem_we;
   logic                       mem_re;
   logic [ADDR_W-1:0]          mem_raddr;
   logic signed [SAMPLE_W-1:0] mem_rdata;

   // misc
   logic [FILL_W-1:0]          len_eff;
   logic [ADDR_W-1:0]          pos_eff;
   logic                       req_fire;
   logic                       out_free;
   logic                       rsp_load;
   logic                       rescan;
   logic                       scan_last;
   logic                       full;
   logic signed [SAMPLE_W-1:0] mul_op;
   logic signed [PROD_W-1:0]   sq_full;
   logic                       rsp_sane;

   sws_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sws_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (CAPACITY)
   ) u_window_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (pos_ff),
      .wdata (sample_ff),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // effective window length, zero acts as one, clipped to capacity
   always_comb begin
      if (cfg.window_len == '0) begin
         len_eff = FILL_W'(1);
      end else if (32'(cfg.window_len) > 32'(CAPACITY)) begin
         len_eff = FILL_W'(CAPACITY);
      end else begin
         len_eff = FILL_W'(cfg.window_len);
      end
   end

   assign pos_eff   = ({1'b0, widx_ff} >= len_eff) ? '0 : widx_ff;
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rescan    = evict_ff && ((old_ff <= min_ff) || (old_ff >= max_ff));
   assign scan_last = (({1'b0, scan_addr_ff} + FILL_W'(1)) == fill_ff);
   assign full      = (fill_ff >= len_eff);

   // shared squarer, one product per cycle
   always_comb begin
      if (rd_vld_ff) begin
         mul_op = mem_rdata;
      end else if (state_ff == ST_OLD) begin
         mul_op = old_ff;
      end else begin
         mul_op = sample_ff;
      end
   end
   assign sq_full = mul_op * mul_op;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_OLD;
         end
         ST_OLD: begin
            state_in = rescan ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_raddr = pos_eff;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            mem_re    = req_valid;
         end
         ST_LOAD: begin
            mem_we = 1'b1;
         end
         ST_SCAN: begin
            mem_re    = 1'b1;
            mem_raddr = scan_addr_ff;
         end
         ST_DONE: begin
            rsp_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // datapath
   always_comb begin
      sample_in     = sample_ff;
      pos_in        = pos_ff;
      old_in        = old_ff;
      evict_in      = evict_ff;
      widx_in       = widx_ff;
      fill_in       = fill_ff;
      sum_in        = sum_ff;
      sumsq_in      = sumsq_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      prod_in       = prod_ff;
      prod_vld_in   = 1'b0;
      prod_neg_in   = 1'b0;
      scan_addr_in  = scan_addr_ff;
      rd_vld_in     = 1'b0;
      scan_first_in = scan_first_ff;

      // retire the pending square into the sum of squares
      if (prod_vld_ff) begin
         if (prod_neg_ff) begin
            sumsq_in = sumsq_ff - {{(SUMSQ_W-PROD_W){1'b0}}, prod_ff};
         end else begin
            sumsq_in = sumsq_ff + {{(SUMSQ_W-PROD_W){1'b0}}, prod_ff};
         end
      end

      // rescan data returning from the ram
      if (rd_vld_ff) begin
         sum_in = sum_ff + {{(SUM_W-SAMPLE_W){mem_rdata[SAMPLE_W-1]}}, mem_rdata};
         if (scan_first_ff || (mem_rdata < min_ff)) begin
            min_in = mem_rdata;
         end
         if (scan_first_ff || (mem_rdata > max_ff)) begin
            max_in = mem_rdata;
         end
         scan_first_in = 1'b0;
         prod_in       = unsigned'(sq_full);
         prod_vld_in   = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sample_in = req_sample;
               pos_in    = pos_eff;
            end
         end
         ST_LOAD: begin
            // ram data is the slot being overwritten
            if (full) begin
               fill_in = len_eff;
            end else begin
               fill_in = fill_ff + FILL_W'(1);
            end
            if (({1'b0, pos_ff} + FILL_W'(1)) >= len_eff) begin
               widx_in = '0;
            end else begin
               widx_in = pos_ff + ADDR_W'(1);
            end
            sum_in = sum_ff + {{(SUM_W-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff}
                   - (full ? {{(SUM_W-SAMPLE_W){mem_rdata[SAMPLE_W-1]}}, mem_rdata}
                           : SUM_W'(0));
            if ((fill_in == FILL_W'(1)) || (sample_ff < min_ff)) begin
               min_in = sample_ff;
            end
            if ((fill_in == FILL_W'(1)) || (sample_ff > max_ff)) begin
               max_in = sample_ff;
            end
            old_in      = mem_rdata;
            evict_in    = full;
            prod_in     = unsigned'(sq_full);
            prod_vld_in = 1'b1;
         end
         ST_OLD: begin
            prod_in = unsigned'(sq_full);
            if (rescan) begin
               // rebuild everything from the stored window
               sum_in        = '0;
               sumsq_in      = '0;
               scan_addr_in  = '0;
               scan_first_in = 1'b1;
            end else begin
               prod_vld_in = evict_ff;
               prod_neg_in = 1'b1;
            end
         end
         ST_SCAN: begin
            scan_addr_in = scan_addr_ff + ADDR_W'(1);
            rd_vld_in    = 1'b1;
         end
         default: begin
            scan_addr_in = scan_addr_ff;
         end
      endcase

      // a length write empties the window
      if (cfg.wr_len) begin
         widx_in  = '0;
         fill_in  = '0;
         sum_in   = '0;
         sumsq_in = '0;
         min_in   = '0;
         max_in   = '0;
      end
   end

   // result register
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         widx_ff       <= '0;
         fill_ff       <= '0;
         sum_ff        <= '0;
         sumsq_ff      <= '0;
         min_ff        <= '0;
         max_ff        <= '0;
         prod_vld_ff   <= 1'b0;
         rd_vld_ff     <= 1'b0;
         scan_first_ff <= 1'b0;
         evict_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         widx_ff       <= widx_in;
         fill_ff       <= fill_in;
         sum_ff        <= sum_in;
         sumsq_ff      <= sumsq_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         prod_vld_ff   <= prod_vld_in;
         rd_vld_ff     <= rd_vld_in;
         scan_first_ff <= scan_first_in;
         evict_ff      <= evict_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      pos_ff       <= pos_in;
      old_ff       <= old_in;
      prod_ff      <= prod_in;
      prod_neg_ff  <= prod_neg_in;
      scan_addr_ff <= scan_addr_in;
      if (rsp_load) begin
         rsp_count_ff   <= COUNT_W'(fill_in);
         rsp_sum_ff     <= sum_in;
         rsp_sum_sq_ff  <= sumsq_in;
         rsp_minimum_ff <= min_in;
         rsp_maximum_ff <= max_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_sum     = rsp_sum_ff;
   assign rsp_sum_sq  = rsp_sum_sq_ff;
   assign rsp_minimum = rsp_minimum_ff;
   assign rsp_maximum = rsp_maximum_ff;

   // checks
   assign rsp_sane = (rsp_minimum_ff <= rsp_maximum_ff) && (rsp_count_ff != '0);

   `SWS_ASSERT_ALWAYS(a_fill_in_window, clock, reset, (fill_ff <= len_eff))
   `SWS_ASSERT_ALWAYS(a_widx_in_window, clock, reset, ({1'b0, widx_ff} < len_eff))
   `SWS_ASSERT_IMPLY(a_scan_only_full, clock, reset, (state_ff == ST_SCAN), (fill_ff == len_eff))
   `SWS_ASSERT_IMPLY(a_rsp_ordered, clock, reset, rsp_valid_ff, rsp_sane)
   `SWS_ASSERT_NEXT(a_accept_loads, clock, reset, (req_fire && !cfg.wr_len), (state_ff == ST_LOAD))

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// self-checking testbench for the sliding window statistics core
`timescale 1ns / 1ps
module tb;
   import sws_pkg::*;

   localparam int WINDOW_CAP = 1024;
   localparam int CYCLE_LIMIT = 20000000;
   localparam int IDLE_STAGE_ITEMS = 630;
   localparam int RANDOM_ITEMS = 1876;
   localparam int DRAIN_CYCLES = WINDOW_CAP + 64;
   localparam int PRINT_CAP = 40;
   localparam int REG_UNMAPPED = REG_WINDOW_LEN + 1;
   localparam logic [CSR_ADDR_W-1:0] LEN_ADDR = CSR_ADDR_W'(4 * REG_WINDOW_LEN);
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR = CSR_ADDR_W'(4 * REG_UNMAPPED);
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

   typedef struct packed {
      logic [COUNT_W-1:0]         count;
      logic signed [SUM_W-1:0]    sum;
      logic [SUMSQ_W-1:0]         sum_sq;
      logic signed [SAMPLE_W-1:0] minimum;
      logic signed [SAMPLE_W-1:0] maximum;
   } window_stats_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [COUNT_W-1:0] rsp_count;
   logic signed [SUM_W-1:0] rsp_sum;
   logic [SUMSQ_W-1:0] rsp_sum_sq;
   logic signed [SAMPLE_W-1:0] rsp_minimum;
   logic signed [SAMPLE_W-1:0] rsp_maximum;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   // samples waiting to be sent and statistics waiting to come back
   logic signed [SAMPLE_W-1:0] sample_queue[$];
   window_stats_type expected_stats[$];
   window_stats_type want;

   // predicted window state
   logic [LEN_W-1:0] len_reg;
   logic signed [SAMPLE_W-1:0] held_samples[0:WINDOW_CAP-1];
   int unsigned ring_pos;
   int unsigned held_count;
   longint window_sum;
   longint window_sum_sq;
   logic signed [SAMPLE_W-1:0] window_min;
   logic signed [SAMPLE_W-1:0] window_max;

   logic signed [SAMPLE_W-1:0] last_sample = '0;
   int sent_count = 0;
   int result_count = 0;
   int error_count = 0;
   int cycle_count = 0;
   int random_total = 0;

   sliding_window_stats_core #(.CAPACITY(WINDOW_CAP)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_count(rsp_count),
      .rsp_sum(rsp_sum), .rsp_sum_sq(rsp_sum_sq),
      .rsp_minimum(rsp_minimum), .rsp_maximum(rsp_maximum),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= PRINT_CAP) $display("error: %s", msg);
   endtask

   // writing the length register empties the window
   function automatic void restart_window(input logic [LEN_W-1:0] len);
      len_reg = len;
      ring_pos = 0;
      held_count = 0;
      window_sum = 0;
      window_sum_sq = 0;
      window_min = '0;
      window_max = '0;
   endfunction

   // push one sample and return the statistics it produces
   function automatic window_stats_type advance_window(input logic signed [SAMPLE_W-1:0] x);
      int unsigned len;
      int unsigned pos;
      logic evicted;
      logic signed [SAMPLE_W-1:0] old;
      logic signed [SAMPLE_W-1:0] v;
      window_stats_type r;
      len = (len_reg == 0) ? 1 : ((len_reg > WINDOW_CAP) ? WINDOW_CAP : len_reg);
      pos = (ring_pos >= len) ? 0 : ring_pos;
      evicted = 1'b0;
      old = '0;
      if (held_count >= len) begin
         evicted = 1'b1;
         old = held_samples[pos];
         held_count = len;
      end else begin
         held_count++;
      end
      held_samples[pos] = x;
      ring_pos = (pos + 1 >= len) ? 0 : pos + 1;
      window_sum += x;
      window_sum_sq += longint'(x) * longint'(x);
      if (held_count == 1 || x < window_min) window_min = x;
      if (held_count == 1 || x > window_max) window_max = x;
      // evicting an extreme forces a rebuild over every held sample
      if (evicted) begin
         window_sum -= old;
         window_sum_sq -= longint'(old) * longint'(old);
         if (old <= window_min || old >= window_max) begin
            window_sum = 0;
            window_sum_sq = 0;
            for (int i = 0; i < held_count; i++) begin
               v = held_samples[i];
               window_sum += v;
               window_sum_sq += longint'(v) * longint'(v);
               if (i == 0 || v < window_min) window_min = v;
               if (i == 0 || v > window_max) window_max = v;
            end
         end
      end
      r.count = held_count[COUNT_W-1:0];
      r.sum = window_sum[SUM_W-1:0];
      r.sum_sq = window_sum_sq[SUMSQ_W-1:0];
      r.minimum = window_min;
      r.maximum = window_max;
      return r;
   endfunction

   // idle rates: sender light and receiver heavy, then swapped, then none
   function automatic int sender_gap_pct();
      if (sent_count < IDLE_STAGE_ITEMS) return 8;
      if (sent_count < 2 * IDLE_STAGE_ITEMS) return 77;
      return 0;
   endfunction

   function automatic int receiver_stall_pct();
      if (sent_count < IDLE_STAGE_ITEMS) return 77;
      if (sent_count < 2 * IDLE_STAGE_ITEMS) return 8;
      return 0;
   endfunction

   // mix of extremes, small values, repeats for ties and full-range values
   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      logic signed [SAMPLE_W-1:0] v;
      case ($urandom_range(0, 9))
         0: begin
            v = SAMPLE_MIN;
         end
         1: begin
            v = SAMPLE_MAX;
         end
         2, 3: begin
            v = SAMPLE_W'(int'($urandom_range(0, 63)) - 32);
         end
         4: begin
            v = last_sample;
         end
         default: begin
            v = SAMPLE_W'($urandom);
         end
      endcase
      last_sample = v;
      return v;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_stats.push_back(advance_window(req_sample));
            sent_count++;
         end
         if (!req_valid || !req_stall) begin
            if (sample_queue.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct()) begin
               req_valid <= 1'b1;
               req_sample <= sample_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_stats.size() == 0) begin
               report_error($sformatf("result %0d arrived with nothing outstanding",
                                      result_count));
            end else begin
               want = expected_stats.pop_front();
               if (rsp_count !== want.count)
                  report_error($sformatf("result %0d count: expected %0d, got %0d",
                                         result_count, want.count, rsp_count));
               if (rsp_sum !== want.sum)
                  report_error($sformatf("result %0d sum: expected %0d, got %0d",
                                         result_count, want.sum, rsp_sum));
               if (rsp_sum_sq !== want.sum_sq)
                  report_error($sformatf("result %0d sum_sq: expected %0d, got %0d",
                                         result_count, want.sum_sq, rsp_sum_sq));
               if (rsp_minimum !== want.minimum)
                  report_error($sformatf("result %0d minimum: expected %0d, got %0d",
                                         result_count, want.minimum, rsp_minimum));
               if (rsp_maximum !== want.maximum)
                  report_error($sformatf("result %0d maximum: expected %0d, got %0d",
                                         result_count, want.maximum, rsp_maximum));
            end
            result_count++;
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct());
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // one register access: setup cycle then access cycle
   task automatic csr_cycle(input logic is_write, input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data,
                            output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (is_write && addr == LEN_ADDR) restart_window(data[LEN_W-1:0]);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] unused;
      csr_cycle(1'b1, addr, data, unused);
   endtask

   task automatic csr_read_expect(input logic [CSR_ADDR_W-1:0] addr,
                                  input logic [CSR_DATA_W-1:0] expected);
      logic [CSR_DATA_W-1:0] got;
      csr_cycle(1'b0, addr, '0, got);
      if (got !== expected)
         report_error($sformatf("register read at %0d: expected %0d, got %0d",
                                addr, expected, got));
   endtask

   // block is idle once every request is sent and every result is back
   task automatic wait_idle();
      while (sample_queue.size() != 0 || req_valid || expected_stats.size() != 0)
         @(negedge clock);
   endtask

   task automatic start_window(input logic [LEN_W-1:0] len);
      wait_idle();
      csr_write(LEN_ADDR, CSR_DATA_W'(len));
      csr_read_expect(LEN_ADDR, CSR_DATA_W'(len));
   endtask

   task automatic push_random(input int n);
      repeat (n) sample_queue.push_back(random_sample());
      random_total += n;
   endtask

   // stimulus
   initial begin
      int pick;
      int len;
      restart_window(LEN_RESET);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_read_expect(LEN_ADDR, CSR_DATA_W'(LEN_RESET));

      // first sample and field extremes at the reset length
      sample_queue.push_back(SAMPLE_MIN);
      sample_queue.push_back(SAMPLE_MAX);
      sample_queue.push_back(24'sd0);
      sample_queue.push_back(-24'sd1);
      sample_queue.push_back(24'sd1);
      sample_queue.push_back(24'h555555);
      sample_queue.push_back(24'hAAAAAA);
      sample_queue.push_back(SAMPLE_MAX);

      // length one, and length zero acting as one: every push after the first evicts
      start_window(11'd1);
      sample_queue.push_back(24'sd5);
      sample_queue.push_back(-24'sd7);
      sample_queue.push_back(-24'sd7);
      start_window(11'd0);
      sample_queue.push_back(SAMPLE_MAX);
      sample_queue.push_back(SAMPLE_MIN);
      sample_queue.push_back(24'sd3);

      // evicting the maximum, then the minimum, with ties
      start_window(11'd3);
      sample_queue.push_back(24'sd10);
      sample_queue.push_back(-24'sd5);
      sample_queue.push_back(24'sd7);
      sample_queue.push_back(24'sd10);
      sample_queue.push_back(-24'sd5);
      sample_queue.push_back(24'sd3);

      // write to an unmapped register leaves the window alone
      wait_idle();
      csr_write(UNMAPPED_ADDR, 32'd5);
      csr_read_expect(LEN_ADDR, 32'd3);
      sample_queue.push_back(SAMPLE_MAX);
      sample_queue.push_back(SAMPLE_MIN);
      sample_queue.push_back(24'sd0);
      sample_queue.push_back(24'sd0);

      // oversize length clamps to full capacity; the first sample is evicted later
      start_window(11'd2047);
      sample_queue.push_back(SAMPLE_MIN);
      random_total++;
      push_random(WINDOW_CAP + 40);
      start_window(11'(WINDOW_CAP));
      push_random(30);
      start_window(11'(WINDOW_CAP + 1));
      push_random(30);

      // random lengths, mostly short so that eviction and rebuild dominate
      while (random_total < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         case (pick)
            0: begin
               len = 0;
            end
            1: begin
               len = 1;
            end
            2: begin
               len = 2;
            end
            3: begin
               len = $urandom_range(WINDOW_CAP + 1, 2047);
            end
            4: begin
               len = $urandom_range(25, 300);
            end
            default: begin
               len = $urandom_range(3, 24);
            end
         endcase
         start_window(11'(len));
         if (pick == 4) push_random(len + $urandom_range(5, 30));
         else if (pick == 3) push_random(10);
         else push_random($urandom_range(10, 60));
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
